>>> rtl/pcap_pkg.sv
package pcap_pkg;

  // Input item as it arrives on the input queue port.
  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  channel;
    logic [15:0] capture_value;
  } in_item_t;

  // Result item as it leaves on the result queue port.
  typedef struct packed {
    logic [2:0]  channel_out;
    logic [2:0]  kind;
    logic [15:0] measured;
    logic        last;
  } out_item_t;

  // Input item modes; the fourth code carries no meaning and is dropped.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Result kinds.
  typedef enum logic [2:0] {
    K_STARTED  = 3'd0,
    K_MEASURED = 3'd1,
    K_TIMEOUT  = 3'd2,
    K_NOTCFG   = 3'd3,
    K_RUNNING  = 3'd4,
    K_IDLEEDGE = 3'd5
  } kind_t;

  // Per-channel capture phase.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_FIRST = 2'd2
  } phase_t;

  // Commands passed from the front end to the execution unit.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_EDGE   = 2'd1,
    OP_TICK   = 2'd2,
    OP_REJECT = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  channel;
    logic [15:0] capture;
  } cmd_t;

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd2;

  localparam logic [15:0] MODULUS_RST = 16'hFFFF;
  localparam logic [7:0]  TIMEOUT_RST = 8'hFF;
  localparam logic [7:0]  ENABLE_RST  = 8'h00;

endpackage

>>> rtl/pcap_fifo.sv
module pcap_fifo #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  T     wr_data,
  output logic full,
  input  logic rd_en,
  output T     rd_data,
  output logic empty
);

  // Two-entry queue; one beat may enter and one leave in the same cycle.
  T           mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_wr ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/pcap_front.sv
module pcap_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  pcap_pkg::in_item_t in_data,
  input  logic [7:0]        channel_enable,
  input  logic              cmd_pop,
  output pcap_pkg::cmd_t    cmd_data,
  output logic              cmd_empty
);

  pcap_pkg::cmd_t cmd_in;
  logic           cmd_wr;
  logic           out_of_range;

  // Classify the incoming beat; checks that need no channel state are made here.
  assign out_of_range = (int'(in_data.channel) >= NUM_CHANNELS);

  always_comb begin
    cmd_in.channel = in_data.channel;
    cmd_in.capture = in_data.capture_value;
    cmd_in.op      = pcap_pkg::OP_REJECT;
    cmd_wr         = push;
    case (in_data.mode)
      pcap_pkg::MODE_START: begin
        if (out_of_range || !channel_enable[in_data.channel]) begin
          cmd_in.op = pcap_pkg::OP_REJECT;
        end else begin
          cmd_in.op = pcap_pkg::OP_START;
        end
      end
      pcap_pkg::MODE_EDGE: begin
        cmd_in.op = out_of_range ? pcap_pkg::OP_REJECT : pcap_pkg::OP_EDGE;
      end
      pcap_pkg::MODE_TICK: begin
        cmd_in.op = pcap_pkg::OP_TICK;
      end
      default: begin
        // The unused mode is accepted and dropped.
        cmd_wr = 1'b0;
      end
    endcase
  end

  // Command queue towards the execution unit.
  pcap_fifo #(
    .T (pcap_pkg::cmd_t)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_data),
    .empty   (cmd_empty)
  );

endmodule

>>> rtl/pcap_back.sv
module pcap_back #(
  parameter int NUM_CHANNELS  = 8,
  parameter int COUNTER_WIDTH = 16,
  parameter int TICK_WIDTH    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcap_pkg::cmd_t      cmd_data,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  input  logic [15:0]         counter_modulus,
  input  logic [7:0]          timeout_ticks,
  output logic                res_push,
  output pcap_pkg::out_item_t res_data,
  input  logic                res_full
);

  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW  = COUNTER_WIDTH;
  localparam int TW  = TICK_WIDTH;
  localparam logic [CHW-1:0] LAST_IDX = CHW'(NUM_CHANNELS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  pcap_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [CHW-1:0]    scan_r, scan_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [2:0]        hold_ch_r, hold_ch_nxt;
  logic [CW-1:0]     fe_rd_r;

  pcap_pkg::phase_t  phase_r [NUM_CHANNELS];
  logic [TW-1:0]     tick_r  [NUM_CHANNELS];
  logic [CW-1:0]     fe_mem  [NUM_CHANNELS];

  logic [CHW-1:0]    idx;
  pcap_pkg::phase_t  cur_phase;
  logic [TW-1:0]     cur_tick, tick_inc;
  logic              ph_we, tk_we, fe_we;
  pcap_pkg::phase_t  ph_wdata;
  logic [TW-1:0]     tk_wdata;

  logic [CW-1:0]     cap_w, mod_p1, diff;
  logic              running, hit;

  // One channel entry is looked at per cycle: the command's channel or the scan index.
  assign idx       = (state_r == ST_SCAN) ? scan_r : CHW'(cmd_r.channel);
  assign cur_phase = phase_r[idx];
  assign cur_tick  = tick_r[idx];
  assign tick_inc  = cur_tick + TW'(1);
  assign running   = (cur_phase != pcap_pkg::PH_IDLE);
  assign hit       = running && (tick_inc == TW'(timeout_ticks));

  // Period arithmetic, wrapping at counter_modulus + 1.
  assign cap_w  = CW'(cmd_r.capture);
  assign mod_p1 = CW'(counter_modulus) + CW'(1);
  assign diff   = (cap_w > fe_rd_r) ? (cap_w - fe_rd_r) : (mod_p1 - (fe_rd_r - cap_w));

  assign cmd_pop = (state_r == ST_IDLE) && !cmd_empty;

  // Sequencer: single commands through the execute state (edges via the read state), ticks as a scan over all channels.
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    scan_nxt     = scan_r;
    hold_v_nxt   = hold_v_r;
    hold_ch_nxt  = hold_ch_r;
    ph_we        = 1'b0;
    ph_wdata     = pcap_pkg::PH_IDLE;
    tk_we        = 1'b0;
    tk_wdata     = '0;
    fe_we        = 1'b0;
    res_push     = 1'b0;
    res_data.channel_out = cmd_r.channel;
    res_data.kind        = pcap_pkg::K_NOTCFG;
    res_data.measured    = '0;
    res_data.last        = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_nxt = cmd_data;
          case (cmd_data.op)
            pcap_pkg::OP_TICK: begin
              scan_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            pcap_pkg::OP_EDGE: state_nxt = ST_READ;
            default:           state_nxt = ST_EXEC;
          endcase
        end
      end
      ST_READ: begin
        // The first-edge store read lands in fe_rd_r for the next cycle.
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (cmd_r.op)
          pcap_pkg::OP_START: begin
            if (!res_full) begin
              res_push  = 1'b1;
              state_nxt = ST_IDLE;
              if (running) begin
                res_data.kind = pcap_pkg::K_RUNNING;
              end else begin
                res_data.kind = pcap_pkg::K_STARTED;
                ph_we    = 1'b1;
                ph_wdata = pcap_pkg::PH_ARMED;
                tk_we    = 1'b1;
                tk_wdata = '0;
              end
            end
          end
          pcap_pkg::OP_EDGE: begin
            if (cur_phase == pcap_pkg::PH_ARMED) begin
              // First edge: remember the counter, no result.
              fe_we     = 1'b1;
              ph_we     = 1'b1;
              ph_wdata  = pcap_pkg::PH_FIRST;
              state_nxt = ST_IDLE;
            end else if (!res_full) begin
              res_push  = 1'b1;
              state_nxt = ST_IDLE;
              if (cur_phase == pcap_pkg::PH_FIRST) begin
                res_data.kind     = pcap_pkg::K_MEASURED;
                res_data.measured = 16'(diff);
                ph_we    = 1'b1;
                ph_wdata = pcap_pkg::PH_IDLE;
              end else begin
                res_data.kind = pcap_pkg::K_IDLEEDGE;
              end
            end
          end
          default: begin
            if (!res_full) begin
              res_push      = 1'b1;
              res_data.kind = pcap_pkg::K_NOTCFG;
              state_nxt     = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        // A timeout held from earlier in the scan leaves when a newer one is found.
        res_data.channel_out = hold_ch_r;
        res_data.kind        = pcap_pkg::K_TIMEOUT;
        res_data.last        = 1'b0;
        if (!(hit && hold_v_r && res_full)) begin
          res_push = hit && hold_v_r;
          if (running) begin
            tk_we    = 1'b1;
            tk_wdata = tick_inc;
          end
          if (hit) begin
            ph_we       = 1'b1;
            ph_wdata    = pcap_pkg::PH_IDLE;
            hold_v_nxt  = 1'b1;
            hold_ch_nxt = 3'(scan_r);
          end
          if (scan_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            scan_nxt = scan_r + CHW'(1);
          end
        end
      end
      ST_FLUSH: begin
        // The final timeout of a tick carries the last flag.
        res_data.channel_out = hold_ch_r;
        res_data.kind        = pcap_pkg::K_TIMEOUT;
        res_data.last        = 1'b1;
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (!res_full) begin
          res_push   = 1'b1;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  // Command and scan payload.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    scan_r    <= scan_nxt;
    hold_ch_r <= hold_ch_nxt;
  end

  // Channel phase and tick count, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase_r[i] <= pcap_pkg::PH_IDLE;
        tick_r[i]  <= '0;
      end
    end else begin
      if (ph_we) begin
        phase_r[idx] <= ph_wdata;
      end
      if (tk_we) begin
        tick_r[idx] <= tk_wdata;
      end
    end
  end

  // First-edge store with registered read.
  always_ff @(posedge clk) begin
    if (fe_we) begin
      fe_mem[idx] <= cap_w;
    end
    fe_rd_r <= fe_mem[idx];
  end

  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");

  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("result written into a full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
      hold_v_r |-> (state_r == ST_SCAN || state_r == ST_FLUSH))
    else $error("held timeout outside a tick scan");

  assert property (@(posedge clk) disable iff (!rst_n)
      (res_push && res_data.kind != pcap_pkg::K_TIMEOUT) |-> res_data.last)
    else $error("single result without last flag");

  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_EXEC && res_push) |=> state_r == ST_IDLE)
    else $error("sequencer did not return after a result");

endmodule

>>> rtl/pulse_period_capture.sv
// Sequence: a start or rejected item goes from the idle state to the execute state, an edge
//   item through the read state first, a tick through a scan of every channel and a flush state.
// A new item is taken only back in the idle state, once the last one is done; the execution
//   sequencer visits one channel entry per cycle unless a full result queue stalls it.
// Reset: synchronous, active low; every channel idle with zero tick count, registers at
//   their reset values, queues empty. The first-edge store is not cleared.
module pulse_period_capture #(
  parameter int NUM_CHANNELS  = 8,
  parameter int COUNTER_WIDTH = 16,
  parameter int TICK_WIDTH    = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  pcap_pkg::in_item_t                  in_data,
  output logic                                empty,
  input  logic                                pop,
  output pcap_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcap_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [15:0] counter_modulus_r;
  logic [7:0]  timeout_ticks_r;
  logic [7:0]  channel_enable_r;

  pcap_pkg::cmd_t      cmd_data;
  logic                cmd_empty, cmd_pop;
  pcap_pkg::out_item_t res_data;
  logic                res_push, res_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_modulus_r <= pcap_pkg::MODULUS_RST;
      timeout_ticks_r   <= pcap_pkg::TIMEOUT_RST;
      channel_enable_r  <= pcap_pkg::ENABLE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pcap_pkg::CFG_MODULUS: counter_modulus_r <= cfg_wdata[15:0];
        pcap_pkg::CFG_TIMEOUT: timeout_ticks_r   <= cfg_wdata[7:0];
        pcap_pkg::CFG_ENABLE:  channel_enable_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Front end: classification and command queue.
  pcap_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .channel_enable (channel_enable_r),
    .cmd_pop        (cmd_pop),
    .cmd_data       (cmd_data),
    .cmd_empty      (cmd_empty)
  );

  // Back end: channel state and execution.
  pcap_back #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .TICK_WIDTH    (TICK_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_data        (cmd_data),
    .cmd_empty       (cmd_empty),
    .cmd_pop         (cmd_pop),
    .counter_modulus (counter_modulus_r),
    .timeout_ticks   (timeout_ticks_r),
    .res_push        (res_push),
    .res_data        (res_data),
    .res_full        (res_full)
  );

  // Result queue towards the consumer.
  pcap_fifo #(
    .T (pcap_pkg::out_item_t)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule
